// ----- sv/thc_pkg.sv -----
// Shared types, register codes, constants and helpers for temperature and humidity compensation.
`default_nettype none
package thc_pkg;

	// 32-bit two's complement word used for all intermediate arithmetic.
	typedef logic signed [31:0] word_t;

	// Configuration register indexes.
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 24;
	localparam logic [CfgIdxW-1:0] REG_TEMP_TRIM_ONE   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_TEMP_TRIM_TWO   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_TEMP_TRIM_THREE = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_HUM_TRIM_TWO    = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_HUM_TRIM_FOUR   = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_HUM_TRIM_FIVE   = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_HUM_BYTE_TRIMS  = 3'd6;

	// Constants of the compensation formulae.
	localparam word_t FINE_OFFSET = 32'sd76800;
	localparam word_t HUM_ROUND   = 32'sd16384;
	localparam word_t C_BIAS      = 32'sd32768;
	localparam word_t E_BIAS      = 32'sd2097152;
	localparam word_t F_ROUND     = 32'sd8192;
	localparam word_t HUM_LIMIT   = 32'sd419430400;
	localparam word_t TEMP_ROUND  = 32'sd128;

	// Trimming coefficients as held in the configuration registers.
	typedef struct packed {
		logic [15:0]        t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic signed [15:0] h2;
		logic signed [11:0] h4;
		logic signed [11:0] h5;
		logic [7:0]         h1;
		logic [7:0]         h3;
		logic signed [7:0]  h6;
	} trim_t;

	// Word leaving the temperature pipeline.
	typedef struct packed {
		logic        valid;
		word_t       fine;
		logic [15:0] raw_humidity;
	} fine_word_t;

	// Word leaving the humidity pipeline.
	typedef struct packed {
		logic        valid;
		word_t       fine;
		logic [23:0] temperature_centi;
		logic [16:0] humidity_frac;
	} result_word_t;

	// Sign and zero extension to a full word.
	function automatic word_t sx8(input logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

	function automatic word_t sx12(input logic [11:0] v);
		return {{20{v[11]}}, v};
	endfunction

	function automatic word_t sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic word_t zx8(input logic [7:0] v);
		return {24'd0, v};
	endfunction

endpackage
`default_nettype wire

// ----- sv/thc_temp_pipe.sv -----
// Temperature pipeline: raw temperature to fine temperature in three stages.
`default_nettype none
module thc_temp_pipe (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire logic               in_valid,
	input  wire logic [19:0]        raw_temperature,
	input  wire logic [15:0]        raw_humidity,
	input  wire thc_pkg::trim_t     trims,
	output thc_pkg::fine_word_t     out
);

	thc_pkg::word_t tdiff;
	thc_pkg::word_t d;

	logic           v_s1, v_s2, v_s3;
	thc_pkg::word_t v1p_s1, dd_s1;
	logic [15:0]    hum_s1, hum_s2, hum_s3;
	thc_pkg::word_t v1_s2, v2p_s2;
	thc_pkg::word_t fine_s3;

	// Differences between the raw reading and trim one.
	always_comb begin
		tdiff = {15'd0, raw_temperature[19:3]} - {15'd0, trims.t1, 1'b0};
		d     = {16'd0, raw_temperature[19:4]} - {16'd0, trims.t1};
	end

	// Valid bits travel with the data and advance together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1 forms both products; stage 2 scales by trim three; stage 3 sums.
	always_ff @(posedge clk) begin
		if (adv) begin
			v1p_s1  <= tdiff * thc_pkg::sx16(trims.t2);
			dd_s1   <= d * d;
			hum_s1  <= raw_humidity;
			v1_s2   <= v1p_s1 >>> 11;
			v2p_s2  <= (dd_s1 >>> 12) * thc_pkg::sx16(trims.t3);
			hum_s2  <= hum_s1;
			fine_s3 <= v1_s2 + (v2p_s2 >>> 14);
			hum_s3  <= hum_s2;
		end
	end

	assign out.valid        = v_s3;
	assign out.fine         = fine_s3;
	assign out.raw_humidity = hum_s3;

endmodule
`default_nettype wire

// ----- sv/thc_hum_pipe.sv -----
// Humidity pipeline: fine temperature and raw humidity to the compensated results.
`default_nettype none
module thc_hum_pipe (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  adv,
	input  wire thc_pkg::fine_word_t   in,
	input  wire thc_pkg::trim_t        trims,
	output thc_pkg::result_word_t      out
);

	localparam int unsigned Depth = 9;

	thc_pkg::word_t x;
	thc_pkg::word_t temp_full;
	thc_pkg::word_t hum_acc;
	thc_pkg::word_t hum_clamped;

	logic [Depth-1:0] v_q;

	thc_pkg::word_t fine_s4, fine_s5, fine_s6, fine_s7, fine_s8;
	thc_pkg::word_t fine_s9, fine_s10, fine_s11, fine_s12;
	logic [23:0]    temp_s4, temp_s5, temp_s6, temp_s7, temp_s8;
	logic [23:0]    temp_s9, temp_s10, temp_s11, temp_s12;
	logic [15:0]    hum_s4;
	thc_pkg::word_t h5x_s4, xh6_s4, xh3_s4;
	thc_pkg::word_t a_s5, a_s6, a_s7, a_s8;
	thc_pkg::word_t b_s5, c_s5;
	thc_pkg::word_t bc_s6;
	thc_pkg::word_t eh2_s7;
	thc_pkg::word_t f_s8;
	thc_pkg::word_t x_s9, x_s10, x_s11;
	thc_pkg::word_t qq_s10;
	thc_pkg::word_t qh_s11;
	logic [16:0]    hum_frac_s12;

	// Temperature in hundredths and the offset fine temperature.
	always_comb begin
		x         = in.fine - thc_pkg::FINE_OFFSET;
		temp_full = ((in.fine <<< 2) + in.fine + thc_pkg::TEMP_ROUND) >>> 8;
	end

	// Final correction and clamp of the humidity accumulator.
	always_comb begin
		hum_acc = x_s11 - (qh_s11 >>> 4);
		if (hum_acc[31]) begin
			hum_clamped = '0;
		end else if (hum_acc > thc_pkg::HUM_LIMIT) begin
			hum_clamped = thc_pkg::HUM_LIMIT;
		end else begin
			hum_clamped = hum_acc;
		end
	end

	// Valid bits shift along with the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[Depth-2:0], in.valid};
		end
	end

	// Each product is registered before it feeds the next multiplication.
	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 4: products of the offset fine temperature.
			fine_s4  <= in.fine;
			temp_s4  <= temp_full[23:0];
			hum_s4   <= in.raw_humidity;
			h5x_s4   <= thc_pkg::sx12(trims.h5) * x;
			xh6_s4   <= x * thc_pkg::sx8(trims.h6);
			xh3_s4   <= x * thc_pkg::zx8(trims.h3);
			// Stage 5: humidity offset term and the two scale terms.
			fine_s5  <= fine_s4;
			temp_s5  <= temp_s4;
			a_s5     <= ($signed({2'b00, hum_s4, 14'd0}) - (thc_pkg::sx12(trims.h4) <<< 20)
			             - h5x_s4 + thc_pkg::HUM_ROUND) >>> 15;
			b_s5     <= xh6_s4 >>> 10;
			c_s5     <= (xh3_s4 >>> 11) + thc_pkg::C_BIAS;
			// Stage 6.
			fine_s6  <= fine_s5;
			temp_s6  <= temp_s5;
			a_s6     <= a_s5;
			bc_s6    <= b_s5 * c_s5;
			// Stage 7.
			fine_s7  <= fine_s6;
			temp_s7  <= temp_s6;
			a_s7     <= a_s6;
			eh2_s7   <= ((bc_s6 >>> 10) + thc_pkg::E_BIAS) * thc_pkg::sx16(trims.h2);
			// Stage 8.
			fine_s8  <= fine_s7;
			temp_s8  <= temp_s7;
			a_s8     <= a_s7;
			f_s8     <= (eh2_s7 + thc_pkg::F_ROUND) >>> 14;
			// Stage 9: uncorrected humidity accumulator.
			fine_s9  <= fine_s8;
			temp_s9  <= temp_s8;
			x_s9     <= a_s8 * f_s8;
			// Stage 10: square of the scaled accumulator.
			fine_s10 <= fine_s9;
			temp_s10 <= temp_s9;
			x_s10    <= x_s9;
			qq_s10   <= (x_s9 >>> 15) * (x_s9 >>> 15);
			// Stage 11: weighted by trim one.
			fine_s11 <= fine_s10;
			temp_s11 <= temp_s10;
			x_s11    <= x_s10;
			qh_s11   <= (qq_s10 >>> 7) * thc_pkg::zx8(trims.h1);
			// Stage 12: corrected, clamped and scaled result.
			fine_s12     <= fine_s11;
			temp_s12     <= temp_s11;
			hum_frac_s12 <= hum_clamped[28:12];
		end
	end

	assign out.valid             = v_q[Depth-1];
	assign out.fine              = fine_s12;
	assign out.temperature_centi = temp_s12;
	assign out.humidity_frac     = hum_frac_s12;

endmodule
`default_nettype wire

// ----- sv/temp_humidity_compensation_unit.sv -----
// Throughput: one word per cycle while the output is not stalled; no stage chains two multiplications.
// The whole pipeline advances when the output stage is empty or is being taken,
// so a stalled output holds every stage and the input is refused meanwhile.
// Reset clears all valid bits and sets every trimming coefficient to zero.
`default_nettype none
module temp_humidity_compensation_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Stream input.
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [39:0]                    s_axis_tdata,  // raw_temperature, raw_humidity
	// Stream output.
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [79:0]                         m_axis_tdata,  // fine_temperature,
	                                                           // temperature_centi, humidity_frac
	// Configuration writes.
	input  wire logic                           cfg_we,
	input  wire logic [thc_pkg::CfgIdxW-1:0]    cfg_index,
	input  wire logic [thc_pkg::CfgDataW-1:0]   cfg_data
);

	thc_pkg::trim_t        trims_q;
	thc_pkg::fine_word_t   fine_word;
	thc_pkg::result_word_t result_word;
	logic                  adv;

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trims_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				thc_pkg::REG_TEMP_TRIM_ONE:   trims_q.t1 <= cfg_data[15:0];
				thc_pkg::REG_TEMP_TRIM_TWO:   trims_q.t2 <= cfg_data[15:0];
				thc_pkg::REG_TEMP_TRIM_THREE: trims_q.t3 <= cfg_data[15:0];
				thc_pkg::REG_HUM_TRIM_TWO:    trims_q.h2 <= cfg_data[15:0];
				thc_pkg::REG_HUM_TRIM_FOUR:   trims_q.h4 <= cfg_data[11:0];
				thc_pkg::REG_HUM_TRIM_FIVE:   trims_q.h5 <= cfg_data[11:0];
				thc_pkg::REG_HUM_BYTE_TRIMS: begin
					trims_q.h1 <= cfg_data[7:0];
					trims_q.h3 <= cfg_data[15:8];
					trims_q.h6 <= cfg_data[23:16];
				end
				default: ;
			endcase
		end
	end

	// Pipeline advance: the last stage is free or its word is taken.
	assign adv           = !result_word.valid || m_axis_tready;
	assign s_axis_tready = adv;

	thc_temp_pipe u_temp (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.in_valid        (s_axis_tvalid),
		.raw_temperature (s_axis_tdata[19:0]),
		.raw_humidity    (s_axis_tdata[35:20]),
		.trims           (trims_q),
		.out             (fine_word)
	);

	thc_hum_pipe u_hum (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.in     (fine_word),
		.trims  (trims_q),
		.out    (result_word)
	);

	// Output word packing.
	assign m_axis_tvalid = result_word.valid;
	assign m_axis_tdata  = {7'd0, result_word.humidity_frac,
	                        result_word.temperature_centi, result_word.fine};

`ifndef ASSERT_OFF
	// The clamp keeps the humidity result within 0 to 100 percent.
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[72:56] <= 17'd102400))
		else $error("humidity result above full scale");

	// A held output word freezes the pipeline, so no input may be taken.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted while output stalled");

	// A stalled output word stays valid and unchanged until it is taken.
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled output word changed");
`endif

endmodule
`default_nettype wire
